@@ rtl/cjt_pkg.sv @@
// Package for the cam joint transform: widths, fixed-point constants and the
// record types that travel down the pipeline. No dependencies.
`timescale 1ns / 1ps

package cjt_pkg;

  localparam int DATA_W        = 32;
  localparam int VEC_W         = 36;
  localparam int ROT_W         = 34;
  localparam int SHIFT_W       = 5;
  localparam int DEF_STAGES    = 24;
  localparam int TRIG_ONE      = 1073741824;
  localparam int TRIG_GAIN_Q30 = 652032874;

  typedef struct packed {
    logic signed [DATA_W-1:0] pitch_x;
    logic signed [DATA_W-1:0] pitch_y;
    logic signed [DATA_W-1:0] slide;
    logic signed [DATA_W-1:0] height;
    logic                     zero;
    logic                     flip;
  } side_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ROT_W-1:0] c;
    logic signed [ROT_W-1:0] s;
  } cordic_t;

endpackage

@@ rtl/cjt_prep.sv @@
// Front end: half-plane fold, magnitude compare, shift search and normalizing
// shift of the slope, in three register stages. Depends on cjt_pkg.
`timescale 1ns / 1ps

module cjt_prep import cjt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] pitch_x,
  input  logic signed [DATA_W-1:0] pitch_y,
  input  logic signed [DATA_W-1:0] slope_x,
  input  logic signed [DATA_W-1:0] slope_y,
  input  logic signed [DATA_W-1:0] slide_distance,
  input  logic signed [DATA_W-1:0] height_offset,
  output logic                     out_valid,
  input  logic                     out_ready,
  output side_t                    out_side,
  output cordic_t                  out_cord
);

  logic                     v1, v2, v3;
  logic                     r1, r2, r3;
  side_t                    side1, side2, side3;
  logic signed [DATA_W:0]   x1, y1, x2, y2;
  logic [DATA_W-1:0]        m1;
  logic [SHIFT_W-1:0]       sh2;
  cordic_t                  cord3;

  logic                     flip_c;
  logic signed [DATA_W:0]   xf_c, yf_c, ay_c;
  logic [SHIFT_W-1:0]       sh_c;
  logic signed [VEC_W-1:0]  xe_c, ye_c;

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    flip_c = slope_y[DATA_W-1];
    xf_c   = flip_c ? -{slope_y[DATA_W-1], slope_y} : {slope_y[DATA_W-1], slope_y};
    yf_c   = flip_c ? -{slope_x[DATA_W-1], slope_x} : {slope_x[DATA_W-1], slope_x};
    ay_c   = yf_c[DATA_W] ? -yf_c : yf_c;
  end

  always_comb begin
    sh_c = '0;
    for (int i = 0; i < 31; i++) begin
      if (m1[i]) begin
        sh_c = SHIFT_W'(30 - i);
      end
    end
    if (m1[DATA_W-1] || m1[30]) begin
      sh_c = '0;
    end
  end

  always_comb begin
    xe_c = {{(VEC_W-DATA_W-1){x2[DATA_W]}}, x2};
    ye_c = {{(VEC_W-DATA_W-1){y2[DATA_W]}}, y2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      side1.pitch_x <= pitch_x;
      side1.pitch_y <= pitch_y;
      side1.slide   <= slide_distance;
      side1.height  <= height_offset;
      side1.zero    <= (slope_x == '0) && (slope_y == '0);
      side1.flip    <= flip_c;
      x1            <= xf_c;
      y1            <= yf_c;
      m1            <= (xf_c[DATA_W-1:0] > ay_c[DATA_W-1:0]) ? xf_c[DATA_W-1:0]
                                                             : ay_c[DATA_W-1:0];
    end
    if (r2 && v1) begin
      side2 <= side1;
      x2    <= x1;
      y2    <= y1;
      sh2   <= sh_c;
    end
    if (r3 && v2) begin
      side3   <= side2;
      cord3.x <= xe_c <<< sh2;
      cord3.y <= ye_c <<< sh2;
      cord3.c <= ROT_W'(TRIG_GAIN_Q30);
      cord3.s <= '0;
    end
  end

  assign out_valid = v3;
  assign out_side  = side3;
  assign out_cord  = cord3;

endmodule

@@ rtl/cjt_cordic_stage.sv @@
// One CORDIC stage: a vectoring step on the slope and, with the same direction
// bit, a rotation step on the unit vector. Depends on cjt_pkg.
`timescale 1ns / 1ps

module cjt_cordic_stage import cjt_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  side_t   in_side,
  input  cordic_t in_cord,
  output logic    out_valid,
  input  logic    out_ready,
  output side_t   out_side,
  output cordic_t out_cord
);

  logic                    valid;
  side_t                   side;
  cordic_t                 cord;
  logic                    dir_c;
  logic signed [VEC_W-1:0] xs_c, ys_c;
  logic signed [ROT_W-1:0] cs_c, ss_c;

  assign in_ready = !valid || out_ready;

  always_comb begin
    dir_c = !in_cord.y[VEC_W-1];
    xs_c  = in_cord.x >>> STAGE;
    ys_c  = in_cord.y >>> STAGE;
    cs_c  = in_cord.c >>> STAGE;
    ss_c  = in_cord.s >>> STAGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      side <= in_side;
      if (dir_c) begin
        cord.x <= in_cord.x + ys_c;
        cord.y <= in_cord.y - xs_c;
        cord.c <= in_cord.c - ss_c;
        cord.s <= in_cord.s + cs_c;
      end else begin
        cord.x <= in_cord.x - ys_c;
        cord.y <= in_cord.y + xs_c;
        cord.c <= in_cord.c + ss_c;
        cord.s <= in_cord.s - cs_c;
      end
    end
  end

  assign out_valid = valid;
  assign out_side  = side;
  assign out_cord  = cord;

endmodule

@@ rtl/cjt_post.sv @@
// Back end: clamp and sign fix of cosine and sine, the two slide products,
// then rounding, subtraction and saturation into the output register.
// Depends on cjt_pkg.
`timescale 1ns / 1ps

module cjt_post import cjt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  side_t                    in_side,
  input  cordic_t                  in_cord,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] cos_theta,
  output logic signed [DATA_W-1:0] sin_theta,
  output logic signed [DATA_W-1:0] shift_x,
  output logic signed [DATA_W-1:0] shift_y,
  output logic signed [DATA_W-1:0] shift_z
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int T_W    = PROD_W - 30;
  localparam int DIFF_W = T_W + 1;
  localparam logic signed [ROT_W-1:0]  ONE_R   = ROT_W'(TRIG_ONE);
  localparam logic signed [ROT_W-1:0]  M_ONE_R = -ROT_W'(TRIG_ONE);
  localparam logic signed [PROD_W-1:0] HALF    = PROD_W'(64'd1 << 29);

  logic                      v1, v2, v3;
  logic                      r1, r2, r3;
  side_t                     side1, side2;
  logic signed [DATA_W-1:0]  c1, s1, c2, s2;
  logic signed [PROD_W-1:0]  prod_x, prod_y;

  logic signed [ROT_W-1:0]   cc_c, sc_c;
  logic signed [DATA_W-1:0]  cf_c, sf_c;
  logic signed [PROD_W-1:0]  slide_e, c_e, s_e;
  logic signed [PROD_W-1:0]  sum_x, sum_y;
  logic signed [DIFF_W-1:0]  dx_c, dy_c;

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [DIFF_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    r = v[DATA_W-1:0];
    if (!v[DIFF_W-1] && (v[DIFF_W-2:DATA_W-1] != '0)) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v[DIFF_W-1] && (v[DIFF_W-2:DATA_W-1] != '1)) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end
    return r;
  endfunction

  assign r3       = !v3 || out_ready;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    cc_c = in_cord.c;
    if (in_cord.c > ONE_R) cc_c = ONE_R;
    if (in_cord.c < M_ONE_R) cc_c = M_ONE_R;
    sc_c = in_cord.s;
    if (in_cord.s > ONE_R) sc_c = ONE_R;
    if (in_cord.s < M_ONE_R) sc_c = M_ONE_R;
    cf_c = in_side.flip ? -cc_c[DATA_W-1:0] : cc_c[DATA_W-1:0];
    sf_c = in_side.flip ? -sc_c[DATA_W-1:0] : sc_c[DATA_W-1:0];
    if (in_side.zero) begin
      cf_c = DATA_W'(TRIG_ONE);
      sf_c = '0;
    end
  end

  always_comb begin
    slide_e = {{DATA_W{side1.slide[DATA_W-1]}}, side1.slide};
    c_e     = {{DATA_W{c1[DATA_W-1]}}, c1};
    s_e     = {{DATA_W{s1[DATA_W-1]}}, s1};
  end

  always_comb begin
    sum_x = prod_x + HALF;
    sum_y = prod_y + HALF;
    dx_c  = {{(DIFF_W-DATA_W){side2.pitch_x[DATA_W-1]}}, side2.pitch_x}
            - {sum_x[PROD_W-1], sum_x[PROD_W-1:30]};
    dy_c  = {{(DIFF_W-DATA_W){side2.pitch_y[DATA_W-1]}}, side2.pitch_y}
            - {sum_y[PROD_W-1], sum_y[PROD_W-1:30]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      side1 <= in_side;
      c1    <= cf_c;
      s1    <= sf_c;
    end
    if (r2 && v1) begin
      side2  <= side1;
      c2     <= c1;
      s2     <= s1;
      prod_x <= slide_e * c_e;
      prod_y <= slide_e * s_e;
    end
    if (r3 && v2) begin
      cos_theta <= c2;
      sin_theta <= s2;
      shift_x   <= sat(dx_c);
      shift_y   <= sat(dy_c);
      shift_z   <= side2.height;
    end
  end

  assign out_valid = v3;

endmodule

@@ rtl/cam_joint_transform.sv @@
// Top level of the cam joint transform: front end, CORDIC stage chain and
// back end. Depends on cjt_pkg, cjt_prep, cjt_cordic_stage and cjt_post.
`timescale 1ns / 1ps

// Usage:
//   Input channel item_valid / item_stall carries one contact point per
//   transaction: pitch point, pitch slope, slide distance and height offset.
//   Output channel result_valid / result_stall returns cosine and sine of
//   the slope angle in Q2.30, the two translated coordinates and the height.
//   Every stage is a register with its own valid bit: three front end stages
//   (fold, shift search, normalize), CORDIC_STAGES stages that each do one
//   vectoring and one rotation step, and three back end stages (clamp,
//   multiply, round and saturate). One transaction enters per cycle while
//   item_stall is low; the chain of CORDIC stages and the two 32 by 32
//   multipliers set the pipeline depth. When result_stall is high, the last
//   result holds and earlier stages keep filling empty slots; item_stall
//   rises only once every stage holds a transaction. Reset clears all valid
//   bits; nothing else needs clearing.

module cam_joint_transform import cjt_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_STAGES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [DATA_W-1:0] pitch_x,
  input  logic signed [DATA_W-1:0] pitch_y,
  input  logic signed [DATA_W-1:0] slope_x,
  input  logic signed [DATA_W-1:0] slope_y,
  input  logic signed [DATA_W-1:0] slide_distance,
  input  logic signed [DATA_W-1:0] height_offset,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] cos_theta,
  output logic signed [DATA_W-1:0] sin_theta,
  output logic signed [DATA_W-1:0] shift_x,
  output logic signed [DATA_W-1:0] shift_y,
  output logic signed [DATA_W-1:0] shift_z
);

  logic    prep_ready;
  logic    valid [0:CORDIC_STAGES];
  logic    ready [0:CORDIC_STAGES];
  side_t   side  [0:CORDIC_STAGES];
  cordic_t cord  [0:CORDIC_STAGES];

  assign item_stall = !prep_ready;

  cjt_prep u_prep (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (item_valid),
    .in_ready       (prep_ready),
    .pitch_x        (pitch_x),
    .pitch_y        (pitch_y),
    .slope_x        (slope_x),
    .slope_y        (slope_y),
    .slide_distance (slide_distance),
    .height_offset  (height_offset),
    .out_valid      (valid[0]),
    .out_ready      (ready[0]),
    .out_side       (side[0]),
    .out_cord       (cord[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    cjt_cordic_stage #(
      .STAGE (g)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_ready  (ready[g]),
      .in_side   (side[g]),
      .in_cord   (cord[g]),
      .out_valid (valid[g+1]),
      .out_ready (ready[g+1]),
      .out_side  (side[g+1]),
      .out_cord  (cord[g+1])
    );
  end

  cjt_post u_post (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[CORDIC_STAGES]),
    .in_ready  (ready[CORDIC_STAGES]),
    .in_side   (side[CORDIC_STAGES]),
    .in_cord   (cord[CORDIC_STAGES]),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .cos_theta (cos_theta),
    .sin_theta (sin_theta),
    .shift_x   (shift_x),
    .shift_y   (shift_y),
    .shift_z   (shift_z)
  );

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for cam_joint_transform: drives contact transactions
// with random idling and stalls and scores every pose against a local model.
// Depends on cjt_pkg and the cam_joint_transform RTL.
`timescale 1ns / 1ps

module testbench import cjt_pkg::*;;

  localparam int     STAGES       = DEF_STAGES;
  localparam int     LATENCY      = STAGES + 6;
  localparam int     RANDOM_ITEMS = 900;
  localparam int     STUCK_LIMIT  = 5000;
  localparam int     IDLE_PCT     = 28;
  localparam longint MAX32        = 64'sd2147483647;
  localparam longint MIN32        = -64'sd2147483648;
  localparam longint HALF_LSB     = 64'sd1 <<< 29;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t pitch_x;
    word_t pitch_y;
    word_t slope_x;
    word_t slope_y;
    word_t slide;
    word_t height;
  } contact_t;

  typedef struct packed {
    word_t cos_v;
    word_t sin_v;
    word_t sx;
    word_t sy;
    word_t sz;
  } pose_t;

  class joint_scoreboard;
    pose_t poses[$];
    int    errors;
    int    checked;

    function longint shifted(longint p, longint slide, longint trig);
      longint t;
      t = (slide * trig + HALF_LSB) >>> 30;
      t = p - t;
      if (t > MAX32) t = MAX32;
      if (t < MIN32) t = MIN32;
      return t;
    endfunction

    function pose_t transform(contact_t k);
      longint x, y, c, s, xs, ys, cs, ss, m, one;
      bit     flip;
      int     i;
      pose_t  p;
      one  = longint'(TRIG_ONE);
      x    = longint'($signed(k.slope_y));
      y    = longint'($signed(k.slope_x));
      flip = 1'b0;
      if (x == 0 && y == 0) begin
        c = one;
        s = 0;
      end else begin
        if (x < 0) begin
          x    = -x;
          y    = -y;
          flip = 1'b1;
        end
        m = (y < 0) ? -y : y;
        if (x > m) m = x;
        while (m < (64'sd1 <<< 30)) begin
          m = m <<< 1;
          x = x <<< 1;
          y = y <<< 1;
        end
        c = longint'(TRIG_GAIN_Q30);
        s = 0;
        for (i = 0; i < STAGES; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          cs = c >>> i;
          ss = s >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            c = c - ss;
            s = s + cs;
          end else begin
            x = x - ys;
            y = y + xs;
            c = c + ss;
            s = s - cs;
          end
        end
        if (c > one) c = one;
        if (c < -one) c = -one;
        if (s > one) s = one;
        if (s < -one) s = -one;
        if (flip) begin
          c = -c;
          s = -s;
        end
      end
      p.cos_v = c[31:0];
      p.sin_v = s[31:0];
      p.sx    = word_t'(shifted(longint'($signed(k.pitch_x)), longint'($signed(k.slide)), c));
      p.sy    = word_t'(shifted(longint'($signed(k.pitch_y)), longint'($signed(k.slide)), s));
      p.sz    = k.height;
      return p;
    endfunction

    function void note(contact_t k);
      poses.push_back(transform(k));
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, word_t got, word_t want);
      if (got !== want)
        report($sformatf("pose %0d %s got %0d expected %0d", checked, name, got, want));
    endtask

    task check(pose_t got);
      pose_t want;
      if (poses.size() == 0) begin
        report($sformatf("pose %0d arrived with no pending transaction", checked));
        return;
      end
      want = poses.pop_front();
      compare_field("cos_theta", got.cos_v, want.cos_v);
      compare_field("sin_theta", got.sin_v, want.sin_v);
      compare_field("shift_x", got.sx, want.sx);
      compare_field("shift_y", got.sy, want.sy);
      compare_field("shift_z", got.sz, want.sz);
      checked++;
    endtask
  endclass

  logic  clk            = 1'b0;
  logic  rst            = 1'b1;
  logic  item_valid     = 1'b0;
  logic  item_stall;
  word_t pitch_x        = '0;
  word_t pitch_y        = '0;
  word_t slope_x        = '0;
  word_t slope_y        = '0;
  word_t slide_distance = '0;
  word_t height_offset  = '0;
  logic  result_valid;
  logic  result_stall   = 1'b0;
  word_t cos_theta;
  word_t sin_theta;
  word_t shift_x;
  word_t shift_y;
  word_t shift_z;

  bit              quiet = 1'b0;
  int              sent  = 0;
  int              stuck = 0;
  joint_scoreboard sb    = new;

  cam_joint_transform #(.CORDIC_STAGES(STAGES)) dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .pitch_x       (pitch_x),
    .pitch_y       (pitch_y),
    .slope_x       (slope_x),
    .slope_y       (slope_y),
    .slide_distance(slide_distance),
    .height_offset (height_offset),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .cos_theta     (cos_theta),
    .sin_theta     (sin_theta),
    .shift_x       (shift_x),
    .shift_y       (shift_y),
    .shift_z       (shift_z)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    result_stall <= !rst && !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : watch
    contact_t k;
    pose_t    p;
    bit       moved;
    if (!rst) begin
      moved = 1'b0;
      if (item_valid && !item_stall) begin
        k = '{pitch_x, pitch_y, slope_x, slope_y, slide_distance, height_offset};
        sb.note(k);
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        p = '{cos_theta, sin_theta, shift_x, shift_y, shift_z};
        sb.check(p);
        moved = 1'b1;
      end
      stuck = moved ? 0 : stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task send(word_t px, word_t py, word_t dx, word_t dy, word_t sl, word_t hz);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid     <= 1'b1;
    pitch_x        <= px;
    pitch_y        <= py;
    slope_x        <= dx;
    slope_y        <= dy;
    slide_distance <= sl;
    height_offset  <= hz;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent++;
  endtask

  function word_t edge_word();
    case ($urandom_range(5))
      0: return word_t'(MAX32);
      1: return word_t'(MIN32);
      2: return '0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    word_t px, py, dx, dy, sl, hz;
    int    n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send(0, 0, 0, 0, 0, 0);
    send(word_t'(MAX32), word_t'(MIN32), 0, 0, word_t'(MAX32), word_t'(MIN32));
    send(32'sh0001_0000, 32'sh0002_0000, 0, 1, 32'sh0001_0000, 32'sh0003_0000);
    send(32'sh0001_0000, 32'sh0002_0000, 1, 0, 32'sh0001_0000, -32'sd1);
    send(32'sh0001_0000, -32'sh0002_0000, 0, -1, 32'sh0001_0000, 0);
    send(-32'sh0001_0000, 32'sh0002_0000, -1, 0, -32'sh0001_0000, 0);
    send(12345, -6789, word_t'(MIN32), word_t'(MIN32), 32'sh0100_0000, 1);
    send(-12345, 6789, word_t'(MAX32), word_t'(MAX32), -32'sh0100_0000, 2);
    send(0, 0, word_t'(MIN32), word_t'(MAX32), word_t'(MAX32), 3);
    send(0, 0, word_t'(MAX32), word_t'(MIN32), word_t'(MIN32), 4);
    send(0, 0, 0, word_t'(MIN32), word_t'(MAX32), 5);
    send(7, -9, 3, -5, 32'sh0000_8000, 6);
    send(word_t'(MAX32), 0, 0, 1, word_t'(MIN32), 7);
    send(word_t'(MIN32), 0, 0, 1, word_t'(MAX32), 8);
    send(0, word_t'(MAX32), 1, 0, word_t'(MIN32), 9);
    send(0, word_t'(MIN32), 1, 0, word_t'(MAX32), 10);
    send(word_t'(MIN32), word_t'(MAX32), 0, -1, word_t'(MIN32), 11);
    send(0, 0, 1, 1, 1, word_t'(MAX32));
    send(0, 0, 1, 1, -1, word_t'(MIN32));
    send(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
         32'sh5555_5555, 32'shAAAA_AAAA);
    send(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
         32'shAAAA_AAAA, 32'sh5555_5555);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 350 && n < 550);
      px = $urandom;
      py = $urandom;
      dx = $urandom;
      dy = $urandom;
      sl = $urandom;
      hz = $urandom;
      case ($urandom_range(9))
        4: begin
          dx = $signed($urandom_range(16)) - 8;
          dy = $signed($urandom_range(16)) - 8;
        end
        5: begin
          dx = 0;
          dy = 0;
        end
        6: begin
          if ($urandom_range(1)) dx = 0;
          else dy = 0;
        end
        7: begin
          px = edge_word();
          py = edge_word();
          dx = edge_word();
          dy = edge_word();
          sl = edge_word();
          hz = edge_word();
        end
        8, 9: begin
          px = px >>> $urandom_range(31);
          py = py >>> $urandom_range(31);
          dx = dx >>> $urandom_range(31);
          dy = dy >>> $urandom_range(31);
          sl = sl >>> $urandom_range(8);
        end
        default: ;
      endcase
      send(px, py, dx, dy, sl, hz);
    end
    quiet = 1'b0;
    item_valid <= 1'b0;

    while (sb.poses.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.poses.size() != 0)
      sb.report($sformatf("%0d poses never arrived", sb.poses.size()));

    $display("sent %0d contact transactions (directed extremes, flips, zero and tiny slopes,",
             sent);
    $display("saturating translations, random content); %0d poses compared, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cjt_pkg.sv
rtl/cjt_prep.sv
rtl/cjt_cordic_stage.sv
rtl/cjt_post.sv
rtl/cam_joint_transform.sv
sim/testbench.sv
